/* rtl/cbd_pkg.sv */
package cbd_pkg;

  localparam int SIZE_BITS  = 32;
  localparam int BYTE_W     = 8;
  localparam int COUNT_W    = 32;
  localparam int KIND_W     = 2;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BIG  = 2'd3;

  localparam logic [0:0] REG_MAX_BODY = 1'b0;

  localparam logic [CFG_DW-1:0] MAX_BODY_RESET = 32'h0010_0000;

  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

  typedef struct packed {
    logic                valid;
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   body_byte;
    logic [COUNT_W-1:0]  consumed_count;
  } cbd_result_t;

endpackage

/* rtl/cbd_cfg.sv */
module cbd_cfg
  import cbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output logic [CFG_DW-1:0] max_body_size
);

  logic [CFG_DW-1:0] max_body_r;
  logic              sel_max;
  logic              wr_en;

  assign sel_max    = (cfg_paddr[CFG_AW-1:2] == REG_MAX_BODY);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && sel_max;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r <= MAX_BODY_RESET;
    end else if (wr_en) begin
      max_body_r <= cfg_pwdata;
    end
  end

  always_comb begin
    unique case (cfg_paddr[CFG_AW-1:2])
      REG_MAX_BODY: cfg_prdata = max_body_r;
      default:      cfg_prdata = '0;
    endcase
  end

  assign max_body_size = max_body_r;

endmodule

/* rtl/cbd_decode.sv */
module cbd_decode
  import cbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               first,
  input  logic [CFG_DW-1:0]  max_body_size,
  output cbd_result_t        res
);

  localparam logic [2:0] PH_SIZE    = 3'd0;
  localparam logic [2:0] PH_SIZE_LF = 3'd1;
  localparam logic [2:0] PH_DATA    = 3'd2;
  localparam logic [2:0] PH_DATA_CR = 3'd3;
  localparam logic [2:0] PH_DATA_LF = 3'd4;
  localparam logic [2:0] PH_LAST_CR = 3'd5;
  localparam logic [2:0] PH_LAST_LF = 3'd6;
  localparam logic [2:0] PH_IDLE    = 3'd7;

  localparam int CMP_W = (SIZE_BITS > COUNT_W) ? SIZE_BITS : COUNT_W;
  localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;
  localparam logic [SIZE_BITS-1:0] SIZE_LIM = SIZE_MAX >> 4;

  logic [2:0]           phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] acc_r, acc_nxt;
  logic                 have_r, have_nxt;
  logic [SIZE_BITS-1:0] left_r, left_nxt;
  logic [COUNT_W-1:0]   total_r, total_nxt;
  logic [COUNT_W-1:0]   cons_r, cons_nxt;

  logic [2:0]           ph;
  logic [SIZE_BITS-1:0] acc;
  logic                 have;
  logic [SIZE_BITS-1:0] left;
  logic [COUNT_W-1:0]   total;
  logic [COUNT_W-1:0]   cons;
  logic [4:0]           hex;
  logic [COUNT_W-1:0]   room;
  logic [CMP_W-1:0]     acc_wide;
  logic                 too_big;

  function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      v = {1'b0, c[3:0] + 4'd9};
    return v;
  endfunction

  // restart folds in ahead of the step
  always_comb begin
    if (first) begin
      ph    = PH_SIZE;
      acc   = '0;
      have  = 1'b0;
      left  = '0;
      total = '0;
      cons  = '0;
    end else begin
      ph    = phase_r;
      acc   = acc_r;
      have  = have_r;
      left  = left_r;
      total = total_r;
      cons  = cons_r;
    end
  end

  assign hex      = hex_digit(data_byte);
  assign room     = max_body_size - total;
  assign acc_wide = CMP_W'(acc);
  assign too_big  = (total > max_body_size) || (acc_wide > CMP_W'(room));

  always_comb begin
    phase_nxt = ph;
    acc_nxt   = acc;
    have_nxt  = have;
    left_nxt  = left;
    total_nxt = total;
    cons_nxt  = cons;
    res       = '0;

    if (ph != PH_IDLE) begin
      if (cons != '1) cons_nxt = cons + 1'b1;
      unique case (ph)
        PH_SIZE: begin
          if (data_byte == CHAR_CR) begin
            if (!have) begin
              res.valid = 1'b1;
              res.kind  = KIND_BAD;
            end else begin
              phase_nxt = PH_SIZE_LF;
            end
          end else if (hex[4]) begin
            res.valid = 1'b1;
            res.kind  = KIND_BAD;
          end else begin
            if (acc > SIZE_LIM) acc_nxt = SIZE_MAX;
            else acc_nxt = {acc[SIZE_BITS-5:0], hex[3:0]};
            have_nxt = 1'b1;
          end
        end
        PH_SIZE_LF: begin
          if (data_byte != CHAR_LF) begin
            res.valid = 1'b1;
            res.kind  = KIND_BAD;
          end else begin
            left_nxt  = acc;
            phase_nxt = (acc == '0) ? PH_LAST_CR : PH_DATA;
          end
        end
        PH_DATA: begin
          left_nxt = left - 1'b1;
          if (left_nxt == '0) phase_nxt = PH_DATA_CR;
          res.valid     = 1'b1;
          res.kind      = KIND_BYTE;
          res.body_byte = data_byte;
        end
        PH_DATA_CR: begin
          if (data_byte != CHAR_CR) begin
            res.valid = 1'b1;
            res.kind  = KIND_BAD;
          end else begin
            phase_nxt = PH_DATA_LF;
          end
        end
        PH_DATA_LF: begin
          if (data_byte != CHAR_LF) begin
            res.valid = 1'b1;
            res.kind  = KIND_BAD;
          end else if (too_big) begin
            res.valid = 1'b1;
            res.kind  = KIND_BIG;
          end else begin
            total_nxt = total + acc_wide[COUNT_W-1:0];
            acc_nxt   = '0;
            have_nxt  = 1'b0;
            phase_nxt = PH_SIZE;
          end
        end
        PH_LAST_CR: begin
          if (data_byte != CHAR_CR) begin
            res.valid = 1'b1;
            res.kind  = KIND_BAD;
          end else begin
            phase_nxt = PH_LAST_LF;
          end
        end
        PH_LAST_LF: begin
          res.valid = 1'b1;
          if (data_byte != CHAR_LF) begin
            res.kind = KIND_BAD;
          end else begin
            res.kind           = KIND_DONE;
            res.consumed_count = cons_nxt;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
      if (res.valid && res.kind != KIND_BYTE) phase_nxt = PH_IDLE;
    end
    if (!step) res.valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIZE;
      acc_r   <= '0;
      have_r  <= 1'b0;
      left_r  <= '0;
      total_r <= '0;
      cons_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      have_r  <= have_nxt;
      left_r  <= left_nxt;
      total_r <= total_nxt;
      cons_r  <= cons_nxt;
    end
  end

endmodule

/* rtl/chunked_body_decoder_core.sv */
// path: an input beat is held in the input register, then its result in the result register
// throughput: one byte per cycle while out_tready takes results; bytes that give no result still take a decode step
// the decoder state advances once per byte, and stalls while the result register holds a result not yet taken
// reset: synchronous active-low rst_n clears both registers' valid flags and the decoder
// state, and sets max_body_size to 1048576
module chunked_body_decoder_core
  import cbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // data_byte
  input  logic              in_tuser,   // first
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata,  // body_byte, consumed_count
  output logic [1:0]        out_tuser,  // result_kind
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic               in_valid_r;
  logic [BYTE_W-1:0]  in_byte_r;
  logic               in_first_r;
  logic               out_valid_r;
  logic [KIND_W-1:0]  out_kind_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               advance;
  logic [CFG_DW-1:0]  max_body_size;
  cbd_result_t        res;

  cbd_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .max_body_size (max_body_size)
  );

  cbd_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .data_byte     (in_byte_r),
    .first         (in_first_r),
    .max_body_size (max_body_size),
    .res           (res)
  );

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r  <= in_tdata;
      in_first_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_kind_r  <= res.kind;
      out_byte_r  <= res.body_byte;
      out_count_r <= res.consumed_count;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_byte_r};
  assign out_tuser  = out_kind_r;

endmodule
